### sv/rau_pkg.sv
// shared types and constants for the fraction arithmetic unit
package rau_pkg;

	localparam logic [2:0] OP_ADD  = 3'd0;
	localparam logic [2:0] OP_SUB  = 3'd1;
	localparam logic [2:0] OP_MUL  = 3'd2;
	localparam logic [2:0] OP_DIV  = 3'd3;
	localparam logic [2:0] OP_GT   = 3'd4;
	localparam logic [2:0] OP_EQ   = 3'd5;
	localparam logic [2:0] OP_NZ   = 3'd6;
	localparam logic [2:0] OP_NONE = 3'd7;

	localparam int IN_W  = 131;
	localparam int OUT_W = 67;

	// shared unit commands
	localparam logic [1:0] UOP_MUL = 2'd0;
	localparam logic [1:0] UOP_REM = 2'd1;
	localparam logic [1:0] UOP_DIV = 2'd2;

	typedef struct packed {
		logic       start;
		logic [1:0] uop;
	} rau_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rau_sts_t;

endpackage

### sv/rau_unit.sv
// shared shift-add multiplier and restoring divider, one bit per cycle
module rau_unit #(
	parameter int WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rau_pkg::rau_cmd_t    cmd,
	input  logic [WIDTH-1:0]     opa,
	input  logic [WIDTH-1:0]     opb,
	output rau_pkg::rau_sts_t    sts,
	output logic [2*WIDTH-1:0]   prod,
	output logic [WIDTH-1:0]     quo,
	output logic [WIDTH-1:0]     rem
);

	localparam int CW = $clog2(WIDTH + 1);

	logic [CW-1:0]      cnt_q;
	logic               busy_q;
	logic               done_q;
	logic               mul_q;
	logic [2*WIDTH-1:0] acc_q;
	logic [WIDTH-1:0]   a_q;
	logic [WIDTH-1:0]   b_q;
	logic [WIDTH:0]     trial;
	logic [WIDTH:0]     rsh;

	assign rsh   = {acc_q[2*WIDTH-1:WIDTH], a_q[WIDTH-1]};
	assign trial = rsh - {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			mul_q  <= 1'b0;
		end else begin
			done_q <= !cmd.start && busy_q && (cnt_q == CW'(1));
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH);
				mul_q  <= (cmd.uop == rau_pkg::UOP_MUL);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= '0;
			a_q   <= opa;
			b_q   <= opb;
		end else if (busy_q) begin
			if (mul_q) begin
				// add then shift right, multiplier bits from lsb
				acc_q <= ({1'b0, acc_q[2*WIDTH-1:WIDTH]} + (a_q[0] ? {1'b0, b_q} : '0))
					<< (WIDTH - 1) | {{WIDTH{1'b0}}, acc_q[WIDTH-1:1]};
				a_q   <= a_q >> 1;
			end else begin
				// restoring division, quotient bits collect in the low half
				if (!trial[WIDTH])
					acc_q[2*WIDTH-1:WIDTH] <= trial[WIDTH-1:0];
				else
					acc_q[2*WIDTH-1:WIDTH] <= rsh[WIDTH-1:0];
				acc_q[WIDTH-1:0] <= {acc_q[WIDTH-2:0], ~trial[WIDTH]};
				a_q <= a_q << 1;
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign prod     = acc_q;
	assign quo      = acc_q[WIDTH-1:0];
	assign rem      = acc_q[2*WIDTH-1:WIDTH];

endmodule

### sv/rational_arithmetic_unit.sv
// fraction arithmetic unit top level: sequencer around one shared mul/div unit
//  channel | dir | payload
//  s_axis  | in  | opcode, a_num, a_den, b_num, b_den
//  m_axis  | out | res_num, res_den, truth, div_by_zero, overflow
// an item runs up to three products, one remainder step per euclid iteration
// and two divisions, all in turn on the single shared unit.
// s_axis_tready is low from acceptance until the result is taken.
// reset clears the sequencer and output valid.
module rational_arithmetic_unit #(
	parameter int WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// opcode[2:0], a_num, a_den, b_num, b_den, zero fill
	input  logic [8*((rau_pkg::IN_W+7)/8)-1:0]  s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// res_num, res_den, truth, div_by_zero, overflow, zero fill
	output logic [8*((rau_pkg::OUT_W+7)/8)-1:0] m_axis_tdata
);

	localparam int W = WIDTH;
	localparam int OB = 8 * ((rau_pkg::OUT_W + 7) / 8);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_M1   = 4'd1;
	localparam logic [3:0] ST_M2   = 4'd2;
	localparam logic [3:0] ST_M3   = 4'd3;
	localparam logic [3:0] ST_COMB = 4'd4;
	localparam logic [3:0] ST_GCD  = 4'd5;
	localparam logic [3:0] ST_D1   = 4'd6;
	localparam logic [3:0] ST_D2   = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;
	localparam logic [3:0] ST_WAIT = 4'd9;

	logic [3:0]   state_q;
	logic         wait_q;
	logic [2:0]   op_q;
	logic [W-1:0] an_q, ad_q, bn_q, bd_q;
	logic [W-1:0] rn_q, rd_q, x_q, y_q;
	logic [2*W-1:0] p1_q, p2_q;
	logic         ovf_q, truth_q, dz_q;
	logic [31:0]  on_q, od_q;
	logic         ovalid_q;

	rau_pkg::rau_cmd_t cmd;
	rau_pkg::rau_sts_t sts;
	logic [W-1:0] opa, opb, quo, rem;
	logic [2*W-1:0] prod;

	rau_unit #(.WIDTH(W)) u_unit (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .opa(opa), .opb(opb),
		.sts(sts), .prod(prod), .quo(quo), .rem(rem)
	);

	function automatic logic [W-1:0] in_w(input logic [31:0] v);
		logic [63:0] e;
		e = {{32{v[31]}}, v};
		return e[W-1:0];
	endfunction

	function automatic logic [W-1:0] mag(input logic [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic [31:0] out32(input logic [W-1:0] v);
		logic [63:0] e;
		e = {{(64-W){v[W-1]}}, v};
		return e[31:0];
	endfunction

	// signed wrap and overflow of a magnitude product
	function automatic logic [W:0] fixp(input logic [2*W-1:0] p, input logic neg);
		logic [W-1:0] lo;
		logic         o;
		lo = neg ? (~p[W-1:0] + 1'b1) : p[W-1:0];
		o  = (p[2*W-1:W] != '0) ||
		     (neg ? (p[W-1:0] > {1'b1, {(W-1){1'b0}}}) : p[W-1]);
		return {o, lo};
	endfunction

	// divide by a zero fraction on the incoming transaction
	logic div0_in;
	assign div0_in = (s_axis_tdata[2:0] == rau_pkg::OP_DIV) &&
		(in_w(s_axis_tdata[98:67]) == '0);

	logic [W:0] f1, f2, f3;
	logic [W-1:0] sum, dif;
	logic neg1, neg2, neg3;

	always_comb begin
		unique case (op_q)
			rau_pkg::OP_MUL: begin
				neg1 = an_q[W-1] ^ bn_q[W-1];
				neg2 = ad_q[W-1] ^ bd_q[W-1];
			end
			rau_pkg::OP_DIV: begin
				neg1 = an_q[W-1] ^ bd_q[W-1];
				neg2 = ad_q[W-1] ^ bn_q[W-1];
			end
			default: begin
				neg1 = an_q[W-1] ^ bd_q[W-1];
				neg2 = bn_q[W-1] ^ ad_q[W-1];
			end
		endcase
		neg3 = ad_q[W-1] ^ bd_q[W-1];
	end

	assign f1  = fixp(p1_q, neg1);
	assign f2  = fixp(p2_q, neg2);
	assign f3  = fixp(prod, neg3);
	assign sum = f1[W-1:0] + f2[W-1:0];
	assign dif = f1[W-1:0] - f2[W-1:0];

	// exact compare of |p1|,|p2| with signs
	logic s1, s2, z1, z2, cgt, ceq, flip;
	always_comb begin
		z1   = (p1_q == '0);
		z2   = (p2_q == '0);
		s1   = neg1 && !z1;
		s2   = neg2 && !z2;
		ceq  = (s1 == s2) && (p1_q == p2_q);
		if (s1 != s2) cgt = s2;
		else cgt = s1 ? (p1_q < p2_q) : (p1_q > p2_q);
		flip = ad_q[W-1] ^ bd_q[W-1];
	end

	logic [W-1:0] g;
	assign g = x_q + y_q;

	always_comb begin
		cmd.start = 1'b0;
		cmd.uop   = rau_pkg::UOP_MUL;
		opa = '0;
		opb = '0;
		unique case (state_q)
			ST_M1: begin
				cmd.start = !wait_q;
				opa = mag(an_q);
				opb = (op_q == rau_pkg::OP_MUL) ? mag(bn_q) : mag(bd_q);
			end
			ST_M2: begin
				cmd.start = !wait_q;
				opa = (op_q == rau_pkg::OP_MUL || op_q == rau_pkg::OP_DIV) ? mag(ad_q)
					: mag(bn_q);
				opb = (op_q == rau_pkg::OP_MUL) ? mag(bd_q)
					: (op_q == rau_pkg::OP_DIV) ? mag(bn_q) : mag(ad_q);
			end
			ST_M3: begin
				cmd.start = !wait_q;
				opa = mag(ad_q);
				opb = mag(bd_q);
			end
			ST_GCD: begin
				cmd.start = !wait_q && x_q != '0 && y_q != '0;
				cmd.uop   = rau_pkg::UOP_REM;
				opa = (x_q > y_q) ? x_q : y_q;
				opb = (x_q > y_q) ? y_q : x_q;
			end
			ST_D1: begin
				cmd.start = !wait_q;
				cmd.uop   = rau_pkg::UOP_DIV;
				opa = mag(rn_q);
				opb = g;
			end
			ST_D2: begin
				cmd.start = !wait_q;
				cmd.uop   = rau_pkg::UOP_DIV;
				opa = mag(rd_q);
				opb = g;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			wait_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.start) wait_q <= 1'b1;
			if (sts.done) wait_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (s_axis_tvalid) begin
					unique case (s_axis_tdata[2:0]) inside
						rau_pkg::OP_NZ, rau_pkg::OP_NONE: state_q <= ST_OUT;
						rau_pkg::OP_DIV: state_q <= div0_in ? ST_OUT : ST_M1;
						default: state_q <= ST_M1;
					endcase
				end
				ST_M1: if (sts.done) state_q <= ST_M2;
				ST_M2: if (sts.done) state_q <= (op_q == rau_pkg::OP_ADD ||
					op_q == rau_pkg::OP_SUB) ? ST_M3 : ST_COMB;
				ST_M3: if (sts.done) state_q <= ST_COMB;
				ST_COMB: state_q <= (op_q == rau_pkg::OP_GT || op_q == rau_pkg::OP_EQ)
					? ST_OUT : ST_GCD;
				ST_GCD: if (!wait_q && (x_q == '0 || y_q == '0) && !sts.done)
					state_q <= (rn_q == '0 || g == '0 || g[W-1]) ? ST_OUT : ST_D1;
				ST_D1: if (sts.done) state_q <= ST_D2;
				ST_D2: if (sts.done) state_q <= ST_OUT;
				ST_OUT: begin
					state_q  <= ST_WAIT;
					ovalid_q <= 1'b1;
				end
				ST_WAIT: if (m_axis_tready) begin
					ovalid_q <= 1'b0;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				op_q    <= s_axis_tdata[2:0];
				an_q    <= in_w(s_axis_tdata[34:3]);
				ad_q    <= in_w(s_axis_tdata[66:35]);
				bn_q    <= in_w(s_axis_tdata[98:67]);
				bd_q    <= in_w(s_axis_tdata[130:99]);
				ovf_q   <= 1'b0;
				truth_q <= (s_axis_tdata[2:0] == rau_pkg::OP_NZ) &&
					(in_w(s_axis_tdata[34:3]) != '0);
				dz_q    <= div0_in;
				rn_q    <= div0_in ? in_w(s_axis_tdata[34:3]) : '0;
				rd_q    <= div0_in ? in_w(s_axis_tdata[66:35]) : '0;
			end
			ST_M1: if (sts.done) p1_q <= prod;
			ST_M2: if (sts.done) p2_q <= prod;
			ST_M3: if (sts.done) begin
				rd_q  <= f3[W-1:0];
				ovf_q <= f3[W];
			end
			ST_COMB: begin
				if (op_q == rau_pkg::OP_GT || op_q == rau_pkg::OP_EQ) begin
					if (ad_q != '0 && bd_q != '0)
						truth_q <= (op_q == rau_pkg::OP_EQ) ? ceq
							: (flip ? (!cgt && !ceq) : cgt);
				end else begin
					if (op_q == rau_pkg::OP_ADD) begin
						rn_q  <= sum;
						ovf_q <= ovf_q | f1[W] | f2[W] |
							(f1[W-1] == f2[W-1] && sum[W-1] != f1[W-1]);
						x_q <= mag(sum);
					end else if (op_q == rau_pkg::OP_SUB) begin
						rn_q  <= dif;
						ovf_q <= ovf_q | f1[W] | f2[W] |
							(f1[W-1] != f2[W-1] && dif[W-1] != f1[W-1]);
						x_q <= mag(dif);
					end else begin
						rn_q  <= f1[W-1:0];
						rd_q  <= f2[W-1:0];
						ovf_q <= f1[W] | f2[W];
						x_q   <= mag(f1[W-1:0]);
					end
					y_q <= (op_q == rau_pkg::OP_ADD || op_q == rau_pkg::OP_SUB)
						? mag(rd_q) : mag(f2[W-1:0]);
				end
			end
			ST_GCD: if (sts.done) begin
				if (x_q > y_q) x_q <= rem;
				else y_q <= rem;
			end
			ST_D1: if (sts.done) rn_q <= rn_q[W-1] ? (~quo + 1'b1) : quo;
			ST_D2: if (sts.done) rd_q <= rd_q[W-1] ? (~quo + 1'b1) : quo;
			ST_OUT: begin
				on_q <= out32(rn_q);
				od_q <= out32(rd_q);
			end
			default: ;
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {{(OB - rau_pkg::OUT_W){1'b0}}, ovf_q, dz_q, truth_q, od_q, on_q};

endmodule

### sim/tb_top.sv
// self-checking testbench for the fraction arithmetic unit
`timescale 1ns / 100ps

module tb_top;

	localparam int IN_BITS  = 8*((rau_pkg::IN_W+7)/8);
	localparam int OUT_BITS = 8*((rau_pkg::OUT_W+7)/8);
	localparam int STALL_LIMIT = 20000;
	localparam int MAX_PRINTS = 20;
	localparam int HOLD_CYCLES = 400;

	localparam logic [31:0] MIN32 = 32'h8000_0000;
	localparam logic [31:0] MAX32 = 32'h7fff_ffff;

	typedef struct packed {
		logic [31:0] num;
		logic [31:0] den;
		logic        truth;
		logic        dz;
		logic        ovf;
	} frac_res_t;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [IN_BITS-1:0]  s_axis_tdata;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [OUT_BITS-1:0] m_axis_tdata;

	frac_res_t expected_q[$];
	int        errors;
	int        idle_cycles;
	bit        hold_req;

	rational_arithmetic_unit #(.WIDTH(32)) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// wrapping arithmetic at 32 bits with overflow detection
	function automatic logic [31:0] mul_wrap(input logic [31:0] a, input logic [31:0] b,
			inout bit ovf);
		longint p;
		p = longint'($signed(a)) * longint'($signed(b));
		if (p > 64'sd2147483647 || p < -64'sd2147483648)
			ovf = 1'b1;
		return p[31:0];
	endfunction

	function automatic logic [31:0] add_wrap(input logic [31:0] a, input logic [31:0] b,
			input bit subtract, inout bit ovf);
		logic [31:0] r;
		r = subtract ? a - b : a + b;
		if ((subtract ? a[31] != b[31] : a[31] == b[31]) && r[31] != a[31])
			ovf = 1'b1;
		return r;
	endfunction

	function automatic longint magnitude(input logic [31:0] v);
		longint s;
		s = longint'($signed(v));
		return (s < 0) ? -s : s;
	endfunction

	// euclid reduction, signs kept as they are
	function automatic void reduce_frac(inout logic [31:0] n, inout logic [31:0] d);
		longint x, y, g, qn, qd;
		if (n == 32'd0)
			return;
		x = magnitude(n);
		y = magnitude(d);
		while (x != 0 && y != 0) begin
			if (x > y)
				x = x % y;
			else
				y = y % x;
		end
		g = x + y;
		if (g == 0 || g >= 64'sd2147483648)
			return;
		qn = magnitude(n) / g;
		qd = magnitude(d) / g;
		n = n[31] ? 32'(-qn) : 32'(qn);
		d = d[31] ? 32'(-qd) : 32'(qd);
	endfunction

	function automatic frac_res_t predict_frac(input logic [2:0] op,
			input logic [31:0] an, input logic [31:0] ad,
			input logic [31:0] bn, input logic [31:0] bd);
		frac_res_t r;
		bit        ovf;
		bit        arith;
		logic [31:0] n, d, t1, t2;
		longint    p, q;
		int        c;
		r = '0;
		ovf = 1'b0;
		arith = 1'b1;
		n = '0;
		d = '0;
		case (op) inside
			rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
				t1 = mul_wrap(an, bd, ovf);
				t2 = mul_wrap(bn, ad, ovf);
				n = add_wrap(t1, t2, op == rau_pkg::OP_SUB, ovf);
				d = mul_wrap(ad, bd, ovf);
			end
			rau_pkg::OP_MUL: begin
				n = mul_wrap(an, bn, ovf);
				d = mul_wrap(ad, bd, ovf);
			end
			rau_pkg::OP_DIV: begin
				if (bn == 32'd0) begin
					n = an;
					d = ad;
					r.dz = 1'b1;
					arith = 1'b0;
				end else begin
					n = mul_wrap(an, bd, ovf);
					d = mul_wrap(ad, bn, ovf);
				end
			end
			rau_pkg::OP_GT, rau_pkg::OP_EQ: begin
				arith = 1'b0;
				if (ad != 32'd0 && bd != 32'd0) begin
					p = longint'($signed(an)) * longint'($signed(bd));
					q = longint'($signed(bn)) * longint'($signed(ad));
					c = (p > q) ? 1 : (p < q) ? -1 : 0;
					if (ad[31] != bd[31])
						c = -c;
					r.truth = (op == rau_pkg::OP_GT) ? (c > 0) : (c == 0);
				end
			end
			rau_pkg::OP_NZ: begin
				arith = 1'b0;
				r.truth = (an != 32'd0);
			end
			default: arith = 1'b0;
		endcase
		if (arith)
			reduce_frac(n, d);
		r.num = n;
		r.den = d;
		r.ovf = ovf;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (errors < MAX_PRINTS)
			$display("error: %s got %h expected %h", what, got, want);
		errors++;
	endtask

	// one transaction on the input side; prediction queued at acceptance
	task automatic send_item(input logic [2:0] op, input logic [31:0] an,
			input logic [31:0] ad, input logic [31:0] bn, input logic [31:0] bd);
		int gap;
		gap = $urandom_range(0, 5);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_BITS'({bd, bn, ad, an, op});
		do @(posedge clk); while (!s_axis_tready);
		expected_q.push_back(predict_frac(op, an, ad, bn, bd));
	endtask

	// value mix: mostly small, some corners, some full range
	function automatic logic [31:0] pick_val();
		case ($urandom_range(0, 9)) inside
			0: return MIN32;
			1: return MAX32;
			2: return 32'($signed($urandom_range(0, 2)) - 1);
			3, 4: return $urandom();
			5: return 32'($urandom_range(0, 200000)) - 32'd100000;
			default: return 32'($urandom_range(0, 60)) - 32'd30;
		endcase
	endfunction

	task automatic test_directed();
		send_item(rau_pkg::OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
		send_item(rau_pkg::OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
		send_item(rau_pkg::OP_MUL, 32'd6, 32'd4, 32'd2, 32'd9);
		send_item(rau_pkg::OP_DIV, 32'd3, 32'd4, 32'd9, 32'd8);
		send_item(rau_pkg::OP_DIV, 32'd5, 32'd7, 32'd0, 32'd3);
		send_item(rau_pkg::OP_DIV, MIN32, MAX32, 32'd0, MIN32);
		send_item(rau_pkg::OP_ADD, 32'd0, 32'd5, 32'd0, 32'd7);
		send_item(rau_pkg::OP_MUL, 32'd4, -32'sd6, 32'd3, 32'd1);
		send_item(rau_pkg::OP_MUL, MAX32, 32'd1, MAX32, 32'd1);
		send_item(rau_pkg::OP_MUL, MIN32, 32'd1, 32'd1, 32'd0);
		send_item(rau_pkg::OP_ADD, MAX32, 32'd1, 32'd1, 32'd1);
		send_item(rau_pkg::OP_SUB, MIN32, 32'd1, 32'd1, 32'd1);
		send_item(rau_pkg::OP_MUL, MIN32, MIN32, MIN32, MIN32);
		send_item(rau_pkg::OP_GT, 32'd1, 32'd2, 32'd1, 32'd3);
		send_item(rau_pkg::OP_GT, 32'd1, -32'sd2, 32'd1, 32'd3);
		send_item(rau_pkg::OP_GT, 32'd1, 32'd0, 32'd1, 32'd3);
		send_item(rau_pkg::OP_EQ, 32'd2, 32'd4, 32'd3, 32'd6);
		send_item(rau_pkg::OP_EQ, -32'sd2, -32'sd4, 32'd1, 32'd2);
		send_item(rau_pkg::OP_EQ, 32'd1, 32'd2, 32'd1, 32'd0);
		send_item(rau_pkg::OP_GT, MAX32, MIN32, MIN32, MAX32);
		send_item(rau_pkg::OP_NZ, 32'd0, 32'd1, 32'd0, 32'd1);
		send_item(rau_pkg::OP_NZ, MIN32, 32'd0, MAX32, 32'd0);
		send_item(rau_pkg::OP_NONE, MAX32, MAX32, MAX32, MAX32);
		send_item(rau_pkg::OP_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff);
	endtask

	task automatic test_random(input int count);
		logic [2:0] op;
		for (int i = 0; i < count; i++) begin
			op = ($urandom_range(0, 30) == 0) ? rau_pkg::OP_NONE
				: 3'($urandom_range(0, 6));
			send_item(op, pick_val(), pick_val(), pick_val(), pick_val());
		end
	endtask

	// receiver holds off for a long stretch while the sender keeps offering items
	task automatic test_backpressure();
		hold_req = 1'b1;
		test_random(20);
	endtask

	// receiver: random stalls, plus one long hold when requested
	initial begin
		int stall;
		bit held;
		held = 1'b0;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 5);
			if (hold_req && !held) begin
				stall = HOLD_CYCLES;
				held = 1'b1;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// result checker
	always @(posedge clk) begin
		frac_res_t want;
		frac_res_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.num   = m_axis_tdata[31:0];
			got.den   = m_axis_tdata[63:32];
			got.truth = m_axis_tdata[64];
			got.dz    = m_axis_tdata[65];
			got.ovf   = m_axis_tdata[66];
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected transaction", got.num, 32'd0);
			end else begin
				want = expected_q.pop_front();
				if (got.num !== want.num)
					report_mismatch("res_num", got.num, want.num);
				if (got.den !== want.den)
					report_mismatch("res_den", got.den, want.den);
				if (got.truth !== want.truth)
					report_mismatch("truth", 32'(got.truth), 32'(want.truth));
				if (got.dz !== want.dz)
					report_mismatch("div_by_zero", 32'(got.dz), 32'(want.dz));
				if (got.ovf !== want.ovf)
					report_mismatch("overflow", 32'(got.ovf), 32'(want.ovf));
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("rational_arithmetic_unit: mismatch");
			$finish;
		end
	end

	initial begin
		hold_req = 1'b0;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random(1000);
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("rational_arithmetic_unit: match");
		else
			$display("rational_arithmetic_unit: mismatch");
		$finish;
	end

endmodule

### sim.f
sv/rau_pkg.sv
sv/rau_unit.sv
sv/rational_arithmetic_unit.sv
sim/tb_top.sv
